@@ hw/rtl/mscls_pkg.sv @@
// ----------------------------------------------------------------------------
// mscls_pkg
// Shared constants, types and the signature ROM for the magic classifier.
// ----------------------------------------------------------------------------
package mscls_pkg;

    localparam int SIG_COUNT    = 91;
    localparam int SIG_MAX      = 21;
    localparam int WINDOW_BYTES = 512;
    localparam int POS_W        = 10;
    localparam int CODE_W       = 7;
    localparam int OFF_W        = 9;
    localparam int LEN_W        = 5;

    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [SIG_COUNT-1:0] alive_t;
    typedef logic [CODE_W-1:0]    code_t;

    // Signature bytes are right aligned: byte k sits at [(len-1-k)*8 +: 8].
    typedef struct packed {
        logic [OFF_W-1:0]     off;
        logic [LEN_W-1:0]     len;
        code_t                code;
        logic [SIG_MAX*8-1:0] bytes;
    } sig_row_t;

    localparam sig_row_t SIG_ROM [SIG_COUNT] = '{
        '{9'd0,   5'd21, 7'd1,  168'h213c617263683e0a64656269616e2d62696e617279},
        '{9'd30,  5'd20, 7'd2,  168'h4d4554412d494e462f6d6f7a696c6c612e727361},
        '{9'd0,   5'd14, 7'd3,  168'h060e2b34020501010d0102010102},
        '{9'd0,   5'd11, 7'd4,  168'h233f52414449414e43450a},
        '{9'd0,   5'd11, 7'd5,  168'h0000001c667479704d3456},
        '{9'd0,   5'd10, 7'd6,  168'h30260b32758e66cf11a6},
        '{9'd31,  5'd8,  7'd7,  168'h6d617472_6f736b61},
        '{9'd0,   5'd8,  7'd8,  168'h00000014_66747970},
        '{9'd0,   5'd8,  7'd9,  168'hd0cf11e0_a1b11ae1},
        '{9'd28,  5'd8,  7'd10, 168'h4f707573_48656164},
        '{9'd0,   5'd8,  7'd11, 168'h52494646_57415645},
        '{9'd0,   5'd8,  7'd12, 168'h774f4646_00010000},
        '{9'd0,   5'd8,  7'd12, 168'h774f4646_4f54544f},
        '{9'd0,   5'd8,  7'd13, 168'h774f4632_00010000},
        '{9'd0,   5'd8,  7'd13, 168'h774f4632_4f54544f},
        '{9'd0,   5'd7,  7'd14, 168'h213c617263683e},
        '{9'd0,   5'd7,  7'd15, 168'h52494646415649},
        '{9'd0,   5'd7,  7'd4,  168'h233f52474245_0a},
        '{9'd4,   5'd7,  7'd16, 168'h667479704d3441},
        '{9'd0,   5'd7,  7'd17, 168'h526172211a0700},
        '{9'd0,   5'd7,  7'd17, 168'h526172211a0701},
        '{9'd0,   5'd6,  7'd18, 168'h377abcaf271c},
        '{9'd0,   5'd6,  7'd19, 168'h2321414d520a},
        '{9'd0,   5'd6,  7'd20, 168'hfd377a585a00},
        '{9'd0,   5'd5,  7'd19, 168'h2321414d52},
        '{9'd0,   5'd5,  7'd21, 168'h4f54544f00},
        '{9'd0,   5'd5,  7'd22, 168'h7b0d746600},
        '{9'd0,   5'd5,  7'd22, 168'h7b0d746600},
        '{9'd257, 5'd5,  7'd23, 168'h7573746172},
        '{9'd0,   5'd5,  7'd24, 168'h0001000000},
        '{9'd0,   5'd4,  7'd25, 168'h49536328},
        '{9'd0,   5'd4,  7'd25, 168'h4d534346},
        '{9'd0,   5'd4,  7'd26, 168'h43723234},
        '{9'd0,   5'd4,  7'd27, 168'h762f3101},
        '{9'd0,   5'd4,  7'd28, 168'h664c6143},
        '{9'd0,   5'd4,  7'd29, 168'h464c4946},
        '{9'd0,   5'd4,  7'd30, 168'h464c5601},
        '{9'd0,   5'd4,  7'd31, 168'h00000100},
        '{9'd0,   5'd4,  7'd32, 168'h4c5a4950},
        '{9'd0,   5'd4,  7'd16, 168'h4d344120},
        '{9'd0,   5'd4,  7'd33, 168'h4d546864},
        '{9'd0,   5'd4,  7'd7,  168'h1a45dfa3},
        '{9'd0,   5'd4,  7'd34, 168'h0000001c},
        '{9'd0,   5'd4,  7'd34, 168'h33677035},
        '{9'd4,   5'd4,  7'd34, 168'h66747970},
        '{9'd0,   5'd4,  7'd35, 168'h00001b00},
        '{9'd0,   5'd4,  7'd36, 168'h4e45531a},
        '{9'd0,   5'd4,  7'd37, 168'h4f676753},
        '{9'd0,   5'd4,  7'd21, 168'h4f54544f},
        '{9'd0,   5'd4,  7'd38, 168'h25504446},
        '{9'd0,   5'd4,  7'd39, 168'h89504e47},
        '{9'd0,   5'd4,  7'd40, 168'h38425053},
        '{9'd0,   5'd4,  7'd17, 168'h52617221},
        '{9'd0,   5'd4,  7'd41, 168'hedabeedb},
        '{9'd0,   5'd4,  7'd42, 168'h53514c69},
        '{9'd0,   5'd4,  7'd43, 168'h3c737667},
        '{9'd0,   5'd4,  7'd44, 168'h49492a00},
        '{9'd0,   5'd4,  7'd44, 168'h4d4d002a},
        '{9'd0,   5'd4,  7'd45, 168'h49492a00},
        '{9'd0,   5'd4,  7'd45, 168'h4d4d002a},
        '{9'd8,   5'd4,  7'd11, 168'h57415645},
        '{9'd0,   5'd4,  7'd46, 168'h1a45dfa3},
        '{9'd8,   5'd4,  7'd47, 168'h57454250},
        '{9'd0,   5'd4,  7'd12, 168'h774f4646},
        '{9'd0,   5'd4,  7'd13, 168'h774f4632},
        '{9'd8,   5'd3,  7'd15, 168'h415649},
        '{9'd0,   5'd3,  7'd48, 168'h425a68},
        '{9'd8,   5'd3,  7'd49, 168'h000001},
        '{9'd8,   5'd3,  7'd49, 168'h010002},
        '{9'd8,   5'd3,  7'd49, 168'h020002},
        '{9'd0,   5'd3,  7'd50, 168'h474946},
        '{9'd0,   5'd3,  7'd51, 168'h1f8b08},
        '{9'd0,   5'd3,  7'd52, 168'hffd8ff},
        '{9'd0,   5'd3,  7'd53, 168'h4949bc},
        '{9'd0,   5'd3,  7'd54, 168'h494433},
        '{9'd0,   5'd3,  7'd35, 168'h000001},
        '{9'd0,   5'd3,  7'd55, 168'h435753},
        '{9'd0,   5'd3,  7'd55, 168'h465753},
        '{9'd0,   5'd2,  7'd56, 168'h424d},
        '{9'd0,   5'd2,  7'd57, 168'h7801},
        '{9'd0,   5'd2,  7'd58, 168'h4d5a},
        '{9'd0,   5'd2,  7'd54, 168'hfffb},
        '{9'd0,   5'd2,  7'd59, 168'h2521},
        '{9'd0,   5'd2,  7'd60, 168'h232f},
        '{9'd1,   5'd2,  7'd55, 168'h5753},
        '{9'd0,   5'd2,  7'd61, 168'h1f9d},
        '{9'd0,   5'd2,  7'd61, 168'h1fa0},
        '{9'd0,   5'd2,  7'd62, 168'h504b},
        '{9'd0,   5'd1,  7'd63, 168'h5b},
        '{9'd0,   5'd1,  7'd63, 168'h7b},
        '{9'd0,   5'd1,  7'd64, 168'h3c}
    };

endpackage

@@ hw/rtl/mscls_match.sv @@
// ----------------------------------------------------------------------------
// mscls_match
// Compares one byte against every signature column covering its position.
// ----------------------------------------------------------------------------
module mscls_match (
    input  mscls_pkg::pos_t   pos,
    input  logic [7:0]        data_byte,
    input  mscls_pkg::alive_t alive,
    output mscls_pkg::alive_t alive_next
);

    for (genvar gi = 0; gi < mscls_pkg::SIG_COUNT; gi++) begin : g_sig
        localparam int OFF = int'(mscls_pkg::SIG_ROM[gi].off);
        localparam int LEN = int'(mscls_pkg::SIG_ROM[gi].len);

        logic miss;

        always_comb
        begin
            int         sh;
            logic [7:0] exp_byte;
            miss = 1'b0;
            for (int k = 0; k < mscls_pkg::SIG_MAX; k++)
            begin
                sh = (k < LEN) ? (LEN - 1 - k) : 0;
                exp_byte = 8'(mscls_pkg::SIG_ROM[gi].bytes >> (sh * 8));
                if (k < LEN && int'(pos) == OFF + k && exp_byte != data_byte)
                begin
                    miss = 1'b1;
                end
            end
        end

        assign alive_next[gi] = alive[gi] & ~miss;
    end

endmodule

@@ hw/rtl/mscls_select.sv @@
// ----------------------------------------------------------------------------
// mscls_select
// Priority pick of the first live signature that ends before the byte count.
// ----------------------------------------------------------------------------
module mscls_select (
    input  mscls_pkg::alive_t alive,
    input  mscls_pkg::pos_t   count,
    output mscls_pkg::code_t  type_code,
    output mscls_pkg::code_t  entry_number
);

    always_comb
    begin
        type_code    = '0;
        entry_number = '0;
        // walk from lowest priority up so the highest-priority hit wins
        for (int i = mscls_pkg::SIG_COUNT - 1; i >= 0; i--)
        begin
            if (alive[i] && (int'(mscls_pkg::SIG_ROM[i].off) +
                             int'(mscls_pkg::SIG_ROM[i].len)) < int'(count))
            begin
                type_code    = mscls_pkg::SIG_ROM[i].code;
                entry_number = mscls_pkg::CODE_W'(i + 1);
            end
        end
    end

endmodule

@@ hw/rtl/magic_signature_classifier.sv @@
// ----------------------------------------------------------------------------
// magic_signature_classifier
// File-type detection from the leading bytes of a file.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle from offset zero on, unless stalled. Each
// byte is registered, then compared combinationally against all 91 ROM
// signatures; on the word flagged last_byte the highest-priority surviving
// signature is registered from the byte register into the output stage, and
// the tracker restarts for the next file. Bytes past the 512-byte window are
// ignored. A result waiting on out_ready stalls only a following last byte.
module magic_signature_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] type_code,
    output logic [6:0] entry_number
);

    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_fire;

    mscls_pkg::alive_t alive_reg;
    mscls_pkg::alive_t alive_upd;
    mscls_pkg::alive_t alive_next;
    mscls_pkg::pos_t   pos_reg;
    mscls_pkg::pos_t   pos_next;
    logic              in_window;

    logic              out_valid_reg;
    mscls_pkg::code_t  type_reg;
    mscls_pkg::code_t  entry_reg;
    mscls_pkg::code_t  sel_type;
    mscls_pkg::code_t  sel_entry;

    assign s1_fire  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    assign in_window = int'(pos_reg) < mscls_pkg::WINDOW_BYTES;

    mscls_match u_match (
        .pos        (pos_reg),
        .data_byte  (s1_byte_reg),
        .alive      (alive_reg),
        .alive_next (alive_upd)
    );

    assign alive_next = in_window ? alive_upd : alive_reg;
    assign pos_next   = in_window ? pos_reg + 1'b1 : pos_reg;

    mscls_select u_select (
        .alive        (alive_next),
        .count        (pos_next),
        .type_code    (sel_type),
        .entry_number (sel_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            alive_reg     <= '1;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    alive_reg <= '1;
                    pos_reg   <= '0;
                end
                else
                begin
                    alive_reg <= alive_next;
                    pos_reg   <= pos_next;
                end
            end
            if (s1_fire && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_fire && s1_last_reg)
        begin
            type_reg  <= sel_type;
            entry_reg <= sel_entry;
        end
    end

    assign out_valid    = out_valid_reg;
    assign type_code    = type_reg;
    assign entry_number = entry_reg;

endmodule
